### design/work_stealing_task_scheduler_defines.svh
// ---------------------------------------------------------------------------
// Work-stealing task scheduler: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WORK_STEALING_TASK_SCHEDULER_DEFINES_SVH
`define WORK_STEALING_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define WSTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsts: implication check failed");

// next-cycle implication
`define WSTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsts: next-cycle check failed");

`endif

### design/wsts_pkg.sv
// ---------------------------------------------------------------------------
// Work-stealing task scheduler package
// Command and status codes, request and response records.
// ---------------------------------------------------------------------------
package wsts_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_REPRI = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] task_id;
    logic [2:0]  pri;
    logic [2:0]  worker;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] task_id;
    logic [2:0]  pri;
    logic [2:0]  qidx;
    logic        stolen;
  } rsp_t;

endpackage

### design/wsts_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module wsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/wsts_seq.sv
// ---------------------------------------------------------------------------
// Scheduler sequencer
// Walks queue counts and queue entries one RAM access per step.
// ---------------------------------------------------------------------------
`include "work_stealing_task_scheduler_defines.svh"

module wsts_seq #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  wsts_pkg::req_t                req,
  input  logic [$clog2(NUM_QUEUES+1)-1:0] active_n,
  output logic                          idle,
  output logic                          res_valid,
  output wsts_pkg::rsp_t                res,
  input  logic                          res_ready
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NW = $clog2(NUM_QUEUES + 1);
  localparam int WW = (NW > 3) ? NW : 3;
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int EW = ID_BITS + 3;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_ENQ_RD, S_ENQ_EV,
    S_FCNT_RD, S_FCNT_EV, S_POP_RD, S_POP_EV, S_SHF_RD, S_SHF_EV,
    S_STEAL_RD, S_STEAL_EV, S_RCNT_RD, S_RCNT_EV, S_RENT_RD, S_RENT_EV,
    S_MV_RD, S_MV_EV, S_DONE
  } state_t;

  function automatic logic [AW-1:0] ent_addr(input logic [QW-1:0] q, input logic [DW-1:0] i);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(i);
  endfunction

  function automatic logic [ID_BITS-1:0] id_ext(input logic [15:0] t);
    logic [63:0] t64;
    t64 = {48'd0, t};
    return t64[ID_BITS-1:0];
  endfunction

  function automatic logic [15:0] id16(input logic [ID_BITS-1:0] e);
    logic [63:0] e64;
    e64 = 64'(e);
    return e64[15:0];
  endfunction

  function automatic logic [2:0] q3(input logic [QW-1:0] q);
    logic [63:0] x64;
    x64 = 64'(q);
    return x64[2:0];
  endfunction

  state_t              st_r, st_nxt;
  wsts_pkg::req_t      cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [NW-1:0]       q_r, q_nxt;
  logic [QW-1:0]       bq_r, bq_nxt;
  logic [CW-1:0]       bc_r, bc_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic                up_r, up_nxt;
  wsts_pkg::rsp_t      res_r, res_nxt;
  logic [NUM_QUEUES-1:0] cvld_r, cvld_nxt;
  logic                cnt_rvld_r;

  logic [QW-1:0] cnt_raddr, cnt_waddr;
  logic          cnt_we;
  logic [CW-1:0] cnt_wdata, cnt_rdata, cnt_eff;
  logic [QW-1:0] ent_rq, ent_wq;
  logic [DW-1:0] ent_ri, ent_wi;
  logic          ent_we;
  logic [EW-1:0] ent_wdata, ent_rdata, mover;
  logic [NW-1:0] q_inc;
  logic [CW-1:0] jm1, jp1, bcm1;
  logic [WW-1:0] w_ext;
  logic [QW-1:0] w_q;
  logic          take;
  logic [CW-1:0] sel_c;
  logic [QW-1:0] sel_q;

  assign cnt_eff = cnt_rvld_r ? cnt_rdata : '0;
  assign q_inc   = q_r + 1'b1;
  assign jm1     = j_r - 1'b1;
  assign jp1     = j_r + 1'b1;
  assign bcm1    = bc_r - 1'b1;
  assign w_ext   = WW'(cmd_r.worker);
  assign w_q     = w_ext[QW-1:0];
  assign mover   = {id_r, cmd_r.pri};
  assign idle    = (st_r == S_IDLE);
  assign res_valid = (st_r == S_DONE);
  assign res     = res_r;

  wsts_ram #(.WIDTH(CW), .DEPTH(NUM_QUEUES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  wsts_ram #(.WIDTH(EW), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_addr(ent_wq, ent_wi)),
    .wdata (ent_wdata),
    .raddr (ent_addr(ent_rq, ent_ri)),
    .rdata (ent_rdata)
  );

  always_comb begin
    st_nxt    = st_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    q_nxt     = q_r;
    bq_nxt    = bq_r;
    bc_nxt    = bc_r;
    j_nxt     = j_r;
    up_nxt    = up_r;
    res_nxt   = res_r;
    cvld_nxt  = cvld_r;
    cnt_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = bq_r;
    cnt_wdata = '0;
    ent_rq    = bq_r;
    ent_ri    = '0;
    ent_we    = 1'b0;
    ent_wq    = bq_r;
    ent_wi    = j_r[DW-1:0];
    ent_wdata = mover;
    take      = 1'b0;
    sel_c     = bc_r;
    sel_q     = bq_r;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = req;
          id_nxt  = id_ext(req.task_id);
          res_nxt = '0;
          q_nxt   = '0;
          bq_nxt  = '0;
          bc_nxt  = '0;
          j_nxt   = '0;
          case (req.cmd)
            wsts_pkg::CMD_ENQ:   st_nxt = S_SCAN_RD;
            wsts_pkg::CMD_FETCH: begin
              if (WW'(req.worker) >= WW'(active_n)) begin
                res_nxt.status = wsts_pkg::ST_NONE;
                st_nxt = S_DONE;
              end else begin
                st_nxt = S_FCNT_RD;
              end
            end
            wsts_pkg::CMD_REPRI: st_nxt = S_RCNT_RD;
            default: begin
              res_nxt.status = wsts_pkg::ST_NONE;
              st_nxt = S_DONE;
            end
          endcase
        end
      end

      // count scan: least loaded for enqueue, busiest other for steal
      S_SCAN_RD: begin
        cnt_raddr = q_r[QW-1:0];
        st_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (cmd_r.cmd == wsts_pkg::CMD_ENQ) begin
          take = (q_r == '0) || (cnt_eff < bc_r);
        end else begin
          take = (WW'(q_r) != w_ext) && (cnt_eff > bc_r);
        end
        if (take) begin
          sel_c = cnt_eff;
          sel_q = q_r[QW-1:0];
        end
        bc_nxt = sel_c;
        bq_nxt = sel_q;
        q_nxt  = q_inc;
        if (q_inc != active_n) begin
          st_nxt = S_SCAN_RD;
        end else if (cmd_r.cmd == wsts_pkg::CMD_ENQ) begin
          if (sel_c == CW'(QUEUE_DEPTH)) begin
            res_nxt.status = wsts_pkg::ST_FULL;
            st_nxt = S_DONE;
          end else begin
            j_nxt  = sel_c;
            st_nxt = S_ENQ_RD;
          end
        end else if (sel_c == '0) begin
          res_nxt.status = wsts_pkg::ST_NONE;
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_STEAL_RD;
        end
      end

      // insertion from the back: shift entries of lower or equal priority up one slot
      S_ENQ_RD: begin
        if (j_r == '0) begin
          ent_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = bc_r + 1'b1;
          cvld_nxt[bq_r] = 1'b1;
          res_nxt.qidx = q3(bq_r);
          st_nxt = S_DONE;
        end else begin
          ent_ri = jm1[DW-1:0];
          st_nxt = S_ENQ_EV;
        end
      end
      S_ENQ_EV: begin
        ent_we = 1'b1;
        if (ent_rdata[2:0] > cmd_r.pri) begin
          cnt_we    = 1'b1;
          cnt_wdata = bc_r + 1'b1;
          cvld_nxt[bq_r] = 1'b1;
          res_nxt.qidx = q3(bq_r);
          st_nxt = S_DONE;
        end else begin
          ent_wdata = ent_rdata;
          j_nxt  = jm1;
          st_nxt = S_ENQ_RD;
        end
      end

      S_FCNT_RD: begin
        cnt_raddr = w_q;
        st_nxt = S_FCNT_EV;
      end
      S_FCNT_EV: begin
        if (cnt_eff != '0) begin
          bq_nxt = w_q;
          bc_nxt = cnt_eff;
          st_nxt = S_POP_RD;
        end else begin
          st_nxt = S_SCAN_RD;
        end
      end
      S_POP_RD: begin
        st_nxt = S_POP_EV;
      end
      S_POP_EV: begin
        res_nxt.task_id = id16(ent_rdata[EW-1:3]);
        res_nxt.pri     = ent_rdata[2:0];
        res_nxt.qidx    = q3(bq_r);
        j_nxt = CW'(1);
        if (bc_r == CW'(1)) begin
          cnt_we = 1'b1;
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_SHF_RD;
        end
      end
      // close the gap at the front
      S_SHF_RD: begin
        ent_ri = j_r[DW-1:0];
        st_nxt = S_SHF_EV;
      end
      S_SHF_EV: begin
        ent_we    = 1'b1;
        ent_wi    = jm1[DW-1:0];
        ent_wdata = ent_rdata;
        j_nxt = jp1;
        if (jp1 == bc_r) begin
          cnt_we    = 1'b1;
          cnt_wdata = bcm1;
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_SHF_RD;
        end
      end

      S_STEAL_RD: begin
        ent_ri = bcm1[DW-1:0];
        st_nxt = S_STEAL_EV;
      end
      S_STEAL_EV: begin
        res_nxt.task_id = id16(ent_rdata[EW-1:3]);
        res_nxt.pri     = ent_rdata[2:0];
        res_nxt.qidx    = q3(bq_r);
        res_nxt.stolen  = 1'b1;
        cnt_we    = 1'b1;
        cnt_wdata = bcm1;
        st_nxt = S_DONE;
      end

      // tag search, queue by queue, front to back
      S_RCNT_RD: begin
        cnt_raddr = q_r[QW-1:0];
        st_nxt = S_RCNT_EV;
      end
      S_RCNT_EV: begin
        bc_nxt = cnt_eff;
        j_nxt  = '0;
        if (cnt_eff != '0) begin
          st_nxt = S_RENT_RD;
        end else begin
          q_nxt = q_inc;
          if (q_inc == active_n) begin
            res_nxt.status = wsts_pkg::ST_NOTFOUND;
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_RCNT_RD;
          end
        end
      end
      S_RENT_RD: begin
        ent_rq = q_r[QW-1:0];
        ent_ri = j_r[DW-1:0];
        st_nxt = S_RENT_EV;
      end
      S_RENT_EV: begin
        if (ent_rdata[EW-1:3] == id_r) begin
          bq_nxt = q_r[QW-1:0];
          res_nxt.qidx = q3(q_r[QW-1:0]);
          up_nxt = (cmd_r.pri > ent_rdata[2:0]);
          if (cmd_r.pri == ent_rdata[2:0]) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_MV_RD;
          end
        end else begin
          j_nxt = jp1;
          if (jp1 != bc_r) begin
            st_nxt = S_RENT_RD;
          end else begin
            q_nxt = q_inc;
            if (q_inc == active_n) begin
              res_nxt.status = wsts_pkg::ST_NOTFOUND;
              st_nxt = S_DONE;
            end else begin
              st_nxt = S_RCNT_RD;
            end
          end
        end
      end
      // move the re-tagged entry toward the front (raised) or back (lowered)
      S_MV_RD: begin
        if (up_r ? (j_r == '0) : (jp1 == bc_r)) begin
          ent_we = 1'b1;
          st_nxt = S_DONE;
        end else begin
          ent_ri = up_r ? jm1[DW-1:0] : jp1[DW-1:0];
          st_nxt = S_MV_EV;
        end
      end
      S_MV_EV: begin
        ent_we = 1'b1;
        if (up_r ? (ent_rdata[2:0] < cmd_r.pri) : (ent_rdata[2:0] > cmd_r.pri)) begin
          ent_wdata = ent_rdata;
          j_nxt  = up_r ? jm1 : jp1;
          st_nxt = S_MV_RD;
        end else begin
          st_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cvld_r <= '0;
    end else begin
      st_r   <= st_nxt;
      cvld_r <= cvld_nxt;
    end
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    q_r        <= q_nxt;
    bq_r       <= bq_nxt;
    bc_r       <= bc_nxt;
    j_r        <= j_nxt;
    up_r       <= up_nxt;
    res_r      <= res_nxt;
    cnt_rvld_r <= cvld_r[cnt_raddr];
  end

  `WSTS_ASSERT_IMP(a_fail_zero, res_valid && (res_r.status != wsts_pkg::ST_OK),
    (res_r.task_id == '0) && (res_r.qidx == '0) && !res_r.stolen)
  `WSTS_ASSERT_IMP(a_steal_fetch, res_valid && res_r.stolen,
    (res_r.status == wsts_pkg::ST_OK) && (cmd_r.cmd == wsts_pkg::CMD_FETCH))
  `WSTS_ASSERT_IMP(a_cnt_range, cnt_we, cnt_wdata <= CW'(QUEUE_DEPTH))
  `WSTS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_r))

endmodule

### design/work_stealing_task_scheduler.sv
// ---------------------------------------------------------------------------
// Work-stealing priority task scheduler
// Per-worker priority queues with enqueue, fetch/steal and reprioritize.
// ---------------------------------------------------------------------------
// - in_*: one transaction per command; in_tuser is the command, in_tdata the
//   task tag, priority and worker. out_*: one result transaction per command,
//   in command order; out_tuser is the status code.
// - cfg_wr_en/cfg_wr_data set the active worker count n; write it only while
//   idle. Zero acts as one, values above NUM_QUEUES saturate.
// - Each step is a RAM read then an evaluate. Enqueue scans the count of
//   every active queue, then shifts entries from the back; own fetch pops
//   the front and shifts the rest forward; steal, when the own queue is
//   empty, scans the counts and takes from the back; reprioritize reads
//   counts, searches entries and moves the entry; a rejected fetch or an
//   unused command goes straight to the result. A full tag search is longest.
// - One command at a time: in_tready is high only while the sequencer idles.
//   A result in the output register lets the next command in while
//   out_tvalid waits; a second result holds the sequencer until it drains.
// - Reset (rst_n low, synchronous) empties every queue and sets the active
//   worker count to 8. Queue slot contents are not cleared.
// ---------------------------------------------------------------------------
module work_stealing_task_scheduler #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: task_id[15:0], priority_req[18:16], worker[21:19], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: out_task_id[15:0], out_priority[18:16], queue_index[21:19],
  //            stolen[22], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  localparam int NW  = $clog2(NUM_QUEUES + 1);
  localparam int AWW = (NW > 4) ? NW : 4;

  logic [3:0]     aw_r;
  logic [NW-1:0]  act_n;
  wsts_pkg::req_t req;
  wsts_pkg::rsp_t seq_res;
  wsts_pkg::rsp_t out_r;
  logic           out_vld_r;
  logic           seq_idle, seq_vld, seq_rdy;

  // clamp the active worker count into 1..NUM_QUEUES
  always_comb begin
    if (aw_r == 4'd0) begin
      act_n = NW'(1);
    end else if (AWW'(aw_r) > AWW'(NUM_QUEUES)) begin
      act_n = NW'(NUM_QUEUES);
    end else begin
      act_n = NW'(aw_r);
    end
  end

  assign req.cmd     = wsts_pkg::cmd_t'(in_tuser);
  assign req.task_id = in_tdata[15:0];
  assign req.pri     = in_tdata[18:16];
  assign req.worker  = in_tdata[21:19];

  assign in_tready = seq_idle;
  // output register loads when empty or draining this cycle
  assign seq_rdy   = !out_vld_r || out_tready;

  wsts_seq #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid),
    .req       (req),
    .active_n  (act_n),
    .idle      (seq_idle),
    .res_valid (seq_vld),
    .res       (seq_res),
    .res_ready (seq_rdy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r      <= 4'd8;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        aw_r <= cfg_wr_data;
      end
      if (seq_rdy) begin
        out_vld_r <= seq_vld;
      end
    end
    if (seq_rdy && seq_vld) begin
      out_r <= seq_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {1'b0, out_r.stolen, out_r.qidx, out_r.pri, out_r.task_id};

endmodule

### dv/wsts_checker.sv
// ---------------------------------------------------------------------------
// Scheduler scoreboard
// Watches both streams, keeps a shadow copy of the queues and checks each
// result transaction against the predicted one.
// ---------------------------------------------------------------------------
module wsts_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ    = 8;
  localparam int DEPTH = 16;

  logic [15:0]    shadow_id  [NQ][DEPTH];
  logic [2:0]     shadow_pri [NQ][DEPTH];
  int             shadow_cnt [NQ];
  logic [3:0]     workers;
  wsts_pkg::rsp_t expected_q[$];

  initial pending = 0;

  function automatic int live_queues();
    if (workers == 0) return 1;
    if (workers > NQ) return NQ;
    return int'(workers);
  endfunction

  function automatic void resort(int q);
    logic [15:0] id;
    logic [2:0]  p;
    int          j;
    for (int i = 1; i < shadow_cnt[q]; i++) begin
      id = shadow_id[q][i];
      p  = shadow_pri[q][i];
      j  = i;
      while (j > 0 && shadow_pri[q][j-1] < p) begin
        shadow_id[q][j]  = shadow_id[q][j-1];
        shadow_pri[q][j] = shadow_pri[q][j-1];
        j--;
      end
      shadow_id[q][j]  = id;
      shadow_pri[q][j] = p;
    end
  endfunction

  function automatic wsts_pkg::rsp_t schedule(logic [1:0] cmd, logic [15:0] id,
                                              logic [2:0] p, logic [2:0] w);
    wsts_pkg::rsp_t r;
    int   n, best, pos, c, victim, maxc;
    bit   hit;
    r = '0;
    n = live_queues();
    case (cmd)
      wsts_pkg::CMD_ENQ: begin
        best = 0;
        for (int i = 1; i < n; i++) if (shadow_cnt[i] < shadow_cnt[best]) best = i;
        if (shadow_cnt[best] >= DEPTH) begin
          r.status = wsts_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_cnt[best] && shadow_pri[best][pos] > p) pos++;
          for (int i = shadow_cnt[best]; i > pos; i--) begin
            shadow_id[best][i]  = shadow_id[best][i-1];
            shadow_pri[best][i] = shadow_pri[best][i-1];
          end
          shadow_id[best][pos]  = id;
          shadow_pri[best][pos] = p;
          shadow_cnt[best]++;
          r.status = wsts_pkg::ST_OK;
          r.qidx   = best[2:0];
        end
      end
      wsts_pkg::CMD_FETCH: begin
        if (w >= n) begin
          r.status = wsts_pkg::ST_NONE;
        end else if (shadow_cnt[w] > 0) begin
          c = shadow_cnt[w];
          r.task_id = shadow_id[w][0];
          r.pri     = shadow_pri[w][0];
          for (int i = 1; i < c; i++) begin
            shadow_id[w][i-1]  = shadow_id[w][i];
            shadow_pri[w][i-1] = shadow_pri[w][i];
          end
          shadow_cnt[w] = c - 1;
          r.status = wsts_pkg::ST_OK;
          r.qidx   = w;
        end else begin
          // steal from the back of the fullest other queue
          victim = 0;
          maxc   = 0;
          for (int i = 0; i < n; i++)
            if (i != w && shadow_cnt[i] > maxc) begin
              maxc   = shadow_cnt[i];
              victim = i;
            end
          if (maxc == 0) begin
            r.status = wsts_pkg::ST_NONE;
          end else begin
            c = maxc - 1;
            r.task_id = shadow_id[victim][c];
            r.pri     = shadow_pri[victim][c];
            shadow_cnt[victim] = c;
            r.status = wsts_pkg::ST_OK;
            r.qidx   = victim[2:0];
            r.stolen = 1'b1;
          end
        end
      end
      wsts_pkg::CMD_REPRI: begin
        hit = 0;
        r.status = wsts_pkg::ST_NOTFOUND;
        for (int q = 0; q < n && !hit; q++)
          for (int e = 0; e < shadow_cnt[q] && !hit; e++)
            if (shadow_id[q][e] == id) begin
              shadow_pri[q][e] = p;
              resort(q);
              r.status = wsts_pkg::ST_OK;
              r.qidx   = q[2:0];
              hit = 1;
            end
      end
      default: r.status = wsts_pkg::ST_NONE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    wsts_pkg::rsp_t exp_r;
    wsts_pkg::rsp_t pred_r;
    if (!rst_n) begin
      for (int q = 0; q < NQ; q++) shadow_cnt[q] = 0;
      workers = 4'd8;
      expected_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_wr_en) workers = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        pred_r = schedule(in_tuser, in_tdata[15:0], in_tdata[18:16], in_tdata[21:19]);
        expected_q = {expected_q, pred_r};
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (out_tuser !== exp_r.status ||
              out_tdata[15:0] !== exp_r.task_id ||
              out_tdata[18:16] !== exp_r.pri ||
              out_tdata[21:19] !== exp_r.qidx ||
              out_tdata[22] !== exp_r.stolen) begin
            if (out_tuser !== exp_r.status)
              $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            if (out_tdata[15:0] !== exp_r.task_id)
              $error("out_task_id: expected %0h, got %0h", exp_r.task_id, out_tdata[15:0]);
            if (out_tdata[18:16] !== exp_r.pri)
              $error("out_priority: expected %0d, got %0d", exp_r.pri, out_tdata[18:16]);
            if (out_tdata[21:19] !== exp_r.qidx)
              $error("queue_index: expected %0d, got %0d", exp_r.qidx, out_tdata[21:19]);
            if (out_tdata[22] !== exp_r.stolen)
              $error("stolen: expected %0d, got %0d", exp_r.stolen, out_tdata[22]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// Scheduler testbench top
// Directed then random command streams across several worker counts, with
// bursty input, stalling output and one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 0;
  logic [3:0]  cfg_wr_data = '0;
  int          fail_count, pending;
  int          cycles = 0;
  bit          hold_off = 0;   // long receiver stall requested by stimulus
  logic [15:0] recent_ids[$];  // tags likely still queued, for reprioritize

  localparam int LIMIT = 2000000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  work_stealing_task_scheduler dut (.*);

  wsts_checker chk (.*);

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: own stall pattern, mostly ready, sometimes long runs of stall
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      mode = $urandom_range(0, 9);
      if (mode < 5) out_tready <= 1;
      else if (mode < 8) out_tready <= 1'($urandom_range(0, 1));
      else begin
        out_tready <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // one transaction on the input stream; called at a falling edge
  task automatic send(wsts_pkg::cmd_t cmd, logic [15:0] id, logic [2:0] p, logic [2:0] w);
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b0, w, p, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (cmd == wsts_pkg::CMD_ENQ) begin
      recent_ids = {recent_ids, id};
      if (recent_ids.size() > 32) recent_ids.delete(0);
    end
  endtask

  task automatic gap();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain_and_config(logic [3:0] value);
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_item();
    int          k;
    logic [15:0] id;
    k  = $urandom_range(0, 99);
    id = 16'($urandom);
    if (k < 45)
      send(wsts_pkg::CMD_ENQ, id, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    else if (k < 80)
      send(wsts_pkg::CMD_FETCH, id, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    else if (k < 97) begin
      if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      send(wsts_pkg::CMD_REPRI, id, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end else
      send(wsts_pkg::CMD_RSVD, id, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    logic [3:0] settings[6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
    int         burst;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every command, steal, miss, full, unused command
    send(wsts_pkg::CMD_FETCH, 16'h0000, 3'd0, 3'd0);   // empty: no task
    send(wsts_pkg::CMD_REPRI, 16'h1234, 3'd7, 3'd0);   // tag not found
    send(wsts_pkg::CMD_ENQ, 16'hFFFF, 3'd7, 3'd7);
    send(wsts_pkg::CMD_ENQ, 16'h0000, 3'd0, 3'd0);
    send(wsts_pkg::CMD_ENQ, 16'hAAAA, 3'd3, 3'd2);
    send(wsts_pkg::CMD_ENQ, 16'h5555, 3'd4, 3'd5);
    send(wsts_pkg::CMD_REPRI, 16'h0000, 3'd7, 3'd0);
    send(wsts_pkg::CMD_FETCH, 16'h0000, 3'd0, 3'd7);   // steal from worker 0's queue
    send(wsts_pkg::CMD_FETCH, 16'h0000, 3'd0, 3'd0);
    send(wsts_pkg::CMD_RSVD, 16'hFFFF, 3'd7, 3'd7);    // unused command
    drain_and_config(4'd1);
    // single queue: same priority newest first, then fill to full
    for (int i = 0; i < 17; i++) send(wsts_pkg::CMD_ENQ, 16'(i + 16'h100), 3'd2, 3'd0);
    send(wsts_pkg::CMD_FETCH, 16'h0, 3'd0, 3'd1);      // inactive worker
    send(wsts_pkg::CMD_FETCH, 16'h0, 3'd0, 3'd0);

    // random phases over several worker counts, with extremes
    foreach (settings[s]) begin
      drain_and_config(settings[s]);
      for (int i = 0; i < 160; i++) begin
        random_item();
        if (s == 2 && i == 40) hold_off = 1;     // block fills and stalls input
        burst = $urandom_range(0, 9);
        if (burst < 3) gap();
      end
    end

    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
